// ----- sv/apl_pkg.sv -----
// Package for the positional array list: sizes, operation codes and the
// control word that the list controller hands to every list cell.
// No dependencies.
package apl_pkg;

  // List geometry
  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Field widths on the ports
  localparam int ACT_W  = 4;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  // Width wide enough to compare a position against the live count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Packed item widths, rounded up to whole bytes
  localparam int IN_BITS   = ACT_W + POS_W + DATA_W;
  localparam int OUT_BITS  = STAT_W + 1 + DATA_W + LEN_W;
  localparam int IN_TDW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_FRONT = 4'd0,
    ACT_INS_AT    = 4'd1,
    ACT_INS_END   = 4'd2,
    ACT_DEL_FRONT = 4'd3,
    ACT_DEL_AT    = 4'd4,
    ACT_DEL_END   = 4'd5,
    ACT_SEARCH    = 4'd6,
    ACT_READ      = 4'd7,
    ACT_WRITE     = 4'd8
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD     = 2'd0,
    CELL_SHIFT_UP = 2'd1,
    CELL_SHIFT_DN = 2'd2,
    CELL_WRITE    = 2'd3
  } cell_op_t;

  // Control word broadcast to the cell row
  typedef struct packed {
    cell_op_t               op;      // entry update for this cycle
    logic [IDX_W-1:0]       at;      // gap, write or read index
    logic [VALUE_BITS-1:0]  value;   // value to insert, write or match
    logic                   load;    // item accepted: capture hit and read bits
    logic                   search;  // search item
    logic                   rd;      // read item with a valid index
    logic [CNT_W-1:0]       count;   // live count before the item
  } cell_ctl_t;

endpackage

// ----- sv/apl_cell.sv -----
// One list cell: holds one entry, takes a neighbor's entry on shifts and
// reports a search hit and its entry for reads.
// Depends on apl_pkg.
module apl_cell (
  input  logic                           clk,
  input  logic [apl_pkg::IDX_W-1:0]      idx,
  input  apl_pkg::cell_ctl_t             ctl,
  input  logic [apl_pkg::VALUE_BITS-1:0] left,
  input  logic [apl_pkg::VALUE_BITS-1:0] right,
  output logic [apl_pkg::VALUE_BITS-1:0] entry,
  output logic                           hit,
  output logic [apl_pkg::VALUE_BITS-1:0] rdq
);
  import apl_pkg::*;

  logic                  live;
  logic [VALUE_BITS-1:0] entry_next;

  assign live = CNT_W'(idx) < ctl.count;

  // Pick the entry for the next cycle
  always_comb begin
    entry_next = entry;
    unique case (ctl.op)
      CELL_SHIFT_UP: begin
        if (idx > ctl.at) begin
          entry_next = left;
        end else if (idx == ctl.at) begin
          entry_next = ctl.value;
        end
      end
      CELL_SHIFT_DN: begin
        if (idx >= ctl.at) begin
          entry_next = right;
        end
      end
      CELL_WRITE: begin
        if (idx == ctl.at) begin
          entry_next = ctl.value;
        end
      end
      default: entry_next = entry;
    endcase
  end

  // Entry storage, undefined until written
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // Capture the search hit and the read word on the pre-update entry
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hit <= ctl.search && live && (entry == ctl.value);
      rdq <= (ctl.rd && (idx == ctl.at)) ? entry : '0;
    end
  end

endmodule

// ----- sv/apl_ctrl.sv -----
// List controller: decodes one item, checks it against the live count,
// keeps the count and drives the control word of the cell row.
// Depends on apl_pkg.
module apl_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [apl_pkg::ACT_W-1:0]   action,
  input  logic [apl_pkg::POS_W-1:0]   position,
  input  logic signed [apl_pkg::DATA_W-1:0] value,
  output apl_pkg::cell_ctl_t          ctl,
  output logic [apl_pkg::STAT_W-1:0]  status,
  output logic [apl_pkg::LEN_W-1:0]   length
);
  import apl_pkg::*;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CMP_W-1:0]      pos_w;
  logic [CMP_W-1:0]      cnt_w;
  logic [VALUE_BITS-1:0] val_ext;
  status_t               st;
  cell_op_t              op;
  logic [IDX_W-1:0]      at;
  logic                  rd;

  assign pos_w   = CMP_W'(position);
  assign cnt_w   = CMP_W'(count);
  assign val_ext = VALUE_BITS'(value);

  // Decode the item and check it against the list length
  always_comb begin
    st         = ST_OK;
    op         = CELL_HOLD;
    at         = IDX_W'(position);
    rd         = 1'b0;
    count_next = count;
    unique case (action)
      ACT_INS_FRONT, ACT_INS_AT, ACT_INS_END: begin
        if (count == CNT_W'(CAPACITY)) begin
          st = ST_FULL;
        end else if (action == ACT_INS_AT && pos_w > cnt_w) begin
          st = ST_BADIDX;
        end else begin
          op         = CELL_SHIFT_UP;
          count_next = count + CNT_W'(1);
          if (action == ACT_INS_FRONT) begin
            at = '0;
          end else if (action == ACT_INS_END) begin
            at = IDX_W'(count);
          end
        end
      end
      ACT_DEL_FRONT, ACT_DEL_AT, ACT_DEL_END: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else if (action == ACT_DEL_AT && pos_w >= cnt_w) begin
          st = ST_BADIDX;
        end else begin
          op         = CELL_SHIFT_DN;
          count_next = count - CNT_W'(1);
          if (action == ACT_DEL_FRONT) begin
            at = '0;
          end else if (action == ACT_DEL_END) begin
            at = IDX_W'(count - CNT_W'(1));
          end
        end
      end
      ACT_READ: begin
        if (pos_w >= cnt_w) begin
          st = ST_BADIDX;
        end else begin
          rd = 1'b1;
        end
      end
      ACT_WRITE: begin
        if (pos_w >= cnt_w) begin
          st = ST_BADIDX;
        end else begin
          op = CELL_WRITE;
        end
      end
      default: st = ST_OK;
    endcase
  end

  // Drive the cell row; hold everything when no item is taken
  always_comb begin
    ctl.op     = accept ? op : CELL_HOLD;
    ctl.at     = at;
    ctl.value  = val_ext;
    ctl.load   = accept;
    ctl.search = (action == ACT_SEARCH);
    ctl.rd     = rd;
    ctl.count  = count;
    status     = st;
    length     = LEN_W'(count_next);
  end

  // Live count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("live count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> (count == $past(count)))
    else $error("live count moved without an item");

  a_count_unit: assert property (@(posedge clk) disable iff (rst)
    accept |=> (count == $past(count) || count == $past(count) + CNT_W'(1) ||
                count == $past(count) - CNT_W'(1)))
    else $error("live count moved by more than one");

endmodule

// ----- sv/positional_array_list_top.sv -----
// Top level of the positional array list: stream ports, list controller,
// row of list cells and the result register.
// Depends on apl_pkg, apl_ctrl and apl_cell.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready  | action, position, value
//  m_axis   | out | m_axis_tvalid/tready  | status, found, read_data, length
//
// Every item is applied to the cell row in the cycle it is accepted; all cells
// shift, write and compare at once. The hit/read capture stage loads when the
// item is accepted, and the output register then loads from the capture stage
// as soon as the output register is free.
// An item is taken every cycle as long as the output side keeps up.
// rst clears the live count and both stages; entries are left as they are.
// A stalled output holds its item and backs up the capture stage, then input.
module positional_array_list_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [3:0] action, [9:4] position, [41:10] value, [47:42] zero
  input  logic [apl_pkg::IN_TDW-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] status, [2] found, [34:3] read_data, [41:35] length, [47:42] zero
  output logic [apl_pkg::OUT_TDW-1:0]  m_axis_tdata
);
  import apl_pkg::*;

  logic                  accept;
  logic                  advance;
  logic                  pend;
  cell_ctl_t             ctl;
  logic [STAT_W-1:0]     status;
  logic [LEN_W-1:0]      length;
  logic [STAT_W-1:0]     pend_status;
  logic [LEN_W-1:0]      pend_length;
  logic [VALUE_BITS-1:0] entry [CAPACITY];
  logic [VALUE_BITS-1:0] rdq   [CAPACITY];
  logic [CAPACITY-1:0]   hit;
  logic                  found_any;
  logic [VALUE_BITS-1:0] rd_any;
  logic [STAT_W-1:0]     out_status;
  logic                  out_found;
  logic [DATA_W-1:0]     out_rdata;
  logic [LEN_W-1:0]      out_length;

  // Handshake: the capture stage moves on whenever the output register is free
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !pend || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  apl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .action   (s_axis_tdata[ACT_W-1:0]),
    .position (s_axis_tdata[ACT_W+POS_W-1:ACT_W]),
    .value    (s_axis_tdata[ACT_W+POS_W+DATA_W-1:ACT_W+POS_W]),
    .ctl      (ctl),
    .status   (status),
    .length   (length)
  );

  // Row of cells, each wired to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left;
    logic [VALUE_BITS-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entry[i+1];
    end
    apl_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .entry (entry[i]),
      .hit   (hit[i]),
      .rdq   (rdq[i])
    );
  end

  // Merge the captured hit and read bits of all cells
  always_comb begin
    found_any = |hit;
    rd_any    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | rdq[i];
    end
  end

  // Capture stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (advance) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status;
      pend_length <= length;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pend) begin
      out_status <= pend_status;
      out_found  <= found_any;
      out_rdata  <= DATA_W'(rd_any);
      out_length <= pend_length;
    end
  end

  assign m_axis_tdata = OUT_TDW'({out_length, out_rdata, out_found, out_status});

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_found) |-> (out_status == ST_OK && out_rdata == '0))
    else $error("found flag with bad status or read data");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status == ST_FULL) |-> (out_length == LEN_W'(CAPACITY)))
    else $error("full status with a short list");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status == ST_EMPTY) |-> (out_length == '0))
    else $error("empty status with live entries");

endmodule
